@@ rtl/core/pgg_pkg.sv @@
// ----------------------------------------------------------------------------
// pgg_pkg
// Shared widths, constants and control types of the prime gap generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgg_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CAND_BITS  = VALUE_BITS + 1;
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * DIV_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int CFG_BITS   = 31;
  localparam int PRIME_BITS = 31;
  localparam int GAP_BITS   = 10;

  localparam logic [GAP_BITS-1:0]   GAP_MAX     = GAP_BITS'(1023);
  localparam logic [VALUE_BITS-1:0] LIMIT_RESET = VALUE_BITS'(100);
  localparam logic [CAND_BITS-1:0]  CAND_RESET  = CAND_BITS'(3);
  localparam logic [VALUE_BITS-1:0] PREV_RESET  = VALUE_BITS'(2);
  localparam logic [CAND_BITS-1:0]  SMALL_PRIME = CAND_BITS'(3);
  localparam logic [1:0]            MOD3_RESET  = 2'd0;
  localparam logic [1:0]            MOD3_LAST   = 2'd2;
  localparam logic [DIV_BITS-1:0]   D_INIT      = DIV_BITS'(5);
  localparam logic [DIV_BITS-1:0]   D_STEP      = DIV_BITS'(6);
  localparam logic [DIV_BITS-1:0]   D_PAIR      = DIV_BITS'(2);
  localparam logic [SQ_BITS-1:0]    SQ_INIT     = SQ_BITS'(25);
  localparam logic [SQ_BITS-1:0]    SQ_STEP_MUL = SQ_BITS'(12);
  localparam logic [SQ_BITS-1:0]    SQ_STEP_ADD = SQ_BITS'(36);

  typedef enum logic [1:0] {
    DIV_SEL_D,
    DIV_SEL_D2
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_MODA,
    ST_MODB,
    ST_EMIT_PRIME,
    ST_EMIT_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     next_cand;
    logic     mod_start;
    div_sel_t div_sel;
    logic     init_d;
    logic     step_d;
    logic     emit_prime;
    logic     emit_done;
  } cmd_t;

  typedef struct packed {
    logic cand_gt_limit;
    logic cand_le3;
    logic cand_even;
    logic cand_div3;
    logic sq_gt_cand;
    logic mod_done;
    logic rem_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/pgg_if.sv @@
// ----------------------------------------------------------------------------
// pgg_if
// Request and result channel interfaces of the prime gap generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pgg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface pgg_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] prime_found;
  logic [9:0]  gap;
  logic        done_res;

  modport source (output valid, output prime_found, output gap, output done_res,
                  input ready);
  modport sink   (input valid, input prime_found, input gap, input done_res,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/pgg_mod_unit.sv @@
// ----------------------------------------------------------------------------
// pgg_mod_unit
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgg_mod_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pgg_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [pgg_pkg::DIV_BITS-1:0]   divisor,
  output logic                               done,
  output logic                               rem_zero
);
  import pgg_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [VALUE_BITS-1:0] num_r;
  logic [DIV_BITS-1:0]   div_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;

  assign trial = {rem_r, num_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(VALUE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[VALUE_BITS-2:0], 1'b0};
      if (!diff[DIV_BITS]) begin
        rem_r <= diff[DIV_BITS-1:0];
      end else begin
        rem_r <= trial[DIV_BITS-1:0];
      end
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire

@@ rtl/core/pgg_datapath.sv @@
// ----------------------------------------------------------------------------
// pgg_datapath
// Scan state, divisor sequence, remainder unit and result word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgg_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pgg_pkg::CFG_BITS-1:0]   cfg_wr_data,
  input  wire logic                          in_restart,
  input  wire pgg_pkg::cmd_t                 cmd,
  output pgg_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pgg_pkg::PRIME_BITS-1:0]      out_prime_found,
  output logic [pgg_pkg::GAP_BITS-1:0]        out_gap,
  output logic                               out_done_res
);
  import pgg_pkg::*;

  logic [VALUE_BITS-1:0] limit_r;
  logic [CAND_BITS-1:0]  cand_r, cand_nxt;
  logic [1:0]            cand_mod3_r, cand_mod3_nxt;
  logic [VALUE_BITS-1:0] prev_r, prev_nxt;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PRIME_BITS-1:0] out_prime_r;
  logic [GAP_BITS-1:0]   out_gap_r;
  logic                  out_done_r;

  logic [CAND_BITS-1:0]  gap_diff;
  logic [GAP_BITS-1:0]   gap_sat;
  logic [DIV_BITS-1:0]   divisor;
  logic                  mod_done;
  logic                  rem_zero;

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_D:  divisor = d_r;
      DIV_SEL_D2: divisor = d_r + D_PAIR;
      default:    divisor = d_r;
    endcase
  end

  pgg_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (cand_r[VALUE_BITS-1:0]),
    .divisor  (divisor),
    .done     (mod_done),
    .rem_zero (rem_zero)
  );

  assign gap_diff = cand_r - {1'b0, prev_r};
  assign gap_sat  = (gap_diff > CAND_BITS'(GAP_MAX)) ? GAP_MAX : gap_diff[GAP_BITS-1:0];

  // candidate residue mod 3 follows the candidate
  always_comb begin
    cand_nxt      = cand_r;
    cand_mod3_nxt = cand_mod3_r;
    prev_nxt      = prev_r;
    if (cmd.load && in_restart) begin
      cand_nxt      = CAND_RESET;
      cand_mod3_nxt = MOD3_RESET;
      prev_nxt      = PREV_RESET;
    end else if (cmd.next_cand || cmd.emit_prime) begin
      cand_nxt      = cand_r + 1'b1;
      cand_mod3_nxt = (cand_mod3_r == MOD3_LAST) ? 2'd0 : cand_mod3_r + 1'b1;
    end
    if (cmd.emit_prime) begin
      prev_nxt = cand_r[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    d_nxt  = d_r;
    sq_nxt = sq_r;
    if (cmd.init_d) begin
      d_nxt  = D_INIT;
      sq_nxt = SQ_INIT;
    end else if (cmd.step_d) begin
      d_nxt  = d_r + D_STEP;
      sq_nxt = sq_r + SQ_STEP_MUL * SQ_BITS'(d_r) + SQ_STEP_ADD;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_prime || cmd.emit_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      cand_r      <= CAND_RESET;
      cand_mod3_r <= MOD3_RESET;
      prev_r      <= PREV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data[VALUE_BITS-1:0];
      end
      cand_r      <= cand_nxt;
      cand_mod3_r <= cand_mod3_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    sq_r <= sq_nxt;
    if (cmd.emit_prime) begin
      out_prime_r <= PRIME_BITS'(cand_r[VALUE_BITS-1:0]);
      out_gap_r   <= gap_sat;
      out_done_r  <= 1'b0;
    end else if (cmd.emit_done) begin
      out_prime_r <= '0;
      out_gap_r   <= '0;
      out_done_r  <= 1'b1;
    end
  end

  assign sts.cand_gt_limit = (cand_r > {1'b0, limit_r});
  assign sts.cand_le3      = (cand_r <= SMALL_PRIME);
  assign sts.cand_even     = ~cand_r[0];
  assign sts.cand_div3     = (cand_mod3_r == MOD3_RESET);
  assign sts.sq_gt_cand    = (sq_r > SQ_BITS'(cand_r));
  assign sts.mod_done      = mod_done;
  assign sts.rem_zero      = rem_zero;
  assign sts.out_free      = ~out_valid_r | out_ready;

  assign out_valid       = out_valid_r;
  assign out_prime_found = out_prime_r;
  assign out_gap         = out_gap_r;
  assign out_done_res    = out_done_r;

endmodule

`default_nettype wire

@@ rtl/core/pgg_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgg_ctrl
// Scan sequencer: candidate checks, trial division order, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pgg_pkg::sts_t sts,
  output pgg_pkg::cmd_t      cmd
);
  import pgg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cand_gt_limit)                   state_nxt = ST_EMIT_DONE;
        else if (sts.cand_le3)                   state_nxt = ST_EMIT_PRIME;
        else if (sts.cand_even || sts.cand_div3) state_nxt = ST_CHECK;
        else                                     state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        state_nxt = sts.sq_gt_cand ? ST_EMIT_PRIME : ST_MODA;
      end
      ST_MODA: begin
        if (sts.mod_done) state_nxt = sts.rem_zero ? ST_CHECK : ST_MODB;
      end
      ST_MODB: begin
        if (sts.mod_done) state_nxt = sts.rem_zero ? ST_CHECK : ST_LOOP;
      end
      ST_EMIT_PRIME, ST_EMIT_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_SEL_D;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        if (!sts.cand_gt_limit && !sts.cand_le3) begin
          if (sts.cand_even || sts.cand_div3) begin
            cmd.next_cand = 1'b1;
          end else begin
            cmd.init_d = 1'b1;
          end
        end
      end
      ST_LOOP: begin
        if (!sts.sq_gt_cand) begin
          cmd.mod_start = 1'b1;
          cmd.div_sel   = DIV_SEL_D;
        end
      end
      ST_MODA: begin
        if (sts.mod_done) begin
          cmd.next_cand = sts.rem_zero;
          cmd.mod_start = ~sts.rem_zero;
          cmd.div_sel   = DIV_SEL_D2;
        end
      end
      ST_MODB: begin
        if (sts.mod_done) begin
          cmd.next_cand = sts.rem_zero;
          cmd.step_d    = ~sts.rem_zero;
        end
      end
      ST_EMIT_PRIME: cmd.emit_prime = sts.out_free;
      ST_EMIT_DONE:  cmd.emit_done  = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/prime_gap_generator_top.sv @@
// ----------------------------------------------------------------------------
// prime_gap_generator_top
// Prime gap generator: trial-division scan, one result word per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : request word, restart = 1 restarts the scan at 3 (previous 2).
//   out_if : result word {prime_found, gap, done_res}; done_res = 1 with zero
//            prime and gap when no prime remains at or below the limit.
//   cfg_wr_en / cfg_wr_data : upper_limit, to be written only while idle;
//            the user is bound to this, the block itself does not enforce it.
// Scan: each candidate passes the check state, which also drops even values
//   and multiples of 3. Others step through divisor pairs 6k-1, 6k+1 up to
//   sqrt(n), each a loop state plus two passes of the shared bit-serial
//   remainder unit; a prime then takes one more loop state and an emit
//   state. On a limit already passed, the check and emit-done states load
//   the result word. One request runs at a time; the next is accepted once
//   the controller returns to idle after loading the result word.
// The result register holds a word while the receiver stalls; the next
//   request is accepted and scanned meanwhile, and its result waits until
//   the held word is taken; no further request is accepted until then.
// Reset: limit 100, candidate 3, previous prime 2, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prime_gap_generator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [pgg_pkg::CFG_BITS-1:0] cfg_wr_data,
  pgg_in_if.sink                           in_if,
  pgg_out_if.source                        out_if
);
  import pgg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pgg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_restart      (in_if.restart),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_prime_found (out_if.prime_found),
    .out_gap         (out_if.gap),
    .out_done_res    (out_if.done_res)
  );

endmodule

`default_nettype wire

@@ rtl/core/pgg_checker.sv @@
// ----------------------------------------------------------------------------
// pgg_checker
// Port-level checks of the prime gap generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [30:0] out_prime_found,
  input wire logic [9:0]  out_gap,
  input wire logic        out_done_res
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while scan in progress");

  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_prime_found == '0 && out_gap == '0)
    else $error("done word carries prime or gap");

  a_prime_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_prime_found != '0 && out_gap != '0)
    else $error("prime word with zero prime or gap");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prime_found)
      && $stable(out_gap) && $stable(out_done_res))
    else $error("result word changed under stall");

endmodule

bind prime_gap_generator_top pgg_checker u_pgg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_prime_found (out_if.prime_found),
  .out_gap         (out_if.gap),
  .out_done_res    (out_if.done_res)
);

`default_nettype wire

@@ verif/pgg_gap_checker.sv @@
// ----------------------------------------------------------------------------
// pgg_gap_checker
// Watches the request, result and limit ports of the prime gap generator,
// predicts each result word by its own trial-division scan and compares the
// words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgg_gap_checker
  import pgg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_BITS-1:0] cfg_wr_data,
  pgg_in_if                        in_if,
  pgg_out_if                       out_if,
  output int                       errors,
  output int                       pending,
  output int                       primes_seen,
  output int                       dones_seen
);

  typedef struct packed {
    logic [PRIME_BITS-1:0] prime;
    logic [GAP_BITS-1:0]   gap;
    logic                  done;
  } gap_word_t;

  gap_word_t expected_gaps[$];

  logic [VALUE_BITS-1:0] limit_q;
  logic [CAND_BITS-1:0]  cand_q;
  logic [VALUE_BITS-1:0] prev_q;

  function automatic bit is_prime(logic [CAND_BITS-1:0] n);
    logic [63:0] d;
    logic [63:0] nw;
    nw = 64'(n);
    if (nw <= 64'd1) return 1'b0;
    if (nw <= 64'd3) return 1'b1;
    if ((nw % 64'd2) == 0 || (nw % 64'd3) == 0) return 1'b0;
    for (d = 64'd5; d * d <= nw; d += 64'd6) begin
      if ((nw % d) == 0 || (nw % (d + 64'd2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic gap_word_t next_gap(logic restart);
    logic [CAND_BITS-1:0] c;
    logic [CAND_BITS-1:0] diff;
    gap_word_t            w;
    if (restart) begin
      cand_q = CAND_RESET;
      prev_q = PREV_RESET;
    end
    w      = '0;
    w.done = 1'b1;
    c      = cand_q;
    while (c <= {1'b0, limit_q}) begin
      if (is_prime(c)) begin
        diff    = c - {1'b0, prev_q};
        w.prime = c[PRIME_BITS-1:0];
        w.gap   = (diff > CAND_BITS'(GAP_MAX)) ? GAP_MAX : diff[GAP_BITS-1:0];
        w.done  = 1'b0;
        prev_q  = c[VALUE_BITS-1:0];
        cand_q  = c + 1'b1;
        return w;
      end
      c = c + 1'b1;
    end
    cand_q = c;
    return w;
  endfunction

  always @(posedge clk) begin
    gap_word_t exp_w;
    if (!rst_n) begin
      limit_q     = LIMIT_RESET;
      cand_q      = CAND_RESET;
      prev_q      = PREV_RESET;
      errors      = 0;
      primes_seen = 0;
      dones_seen  = 0;
      expected_gaps.delete();
      pending     = 0;
    end else begin
      if (cfg_wr_en) limit_q = cfg_wr_data[VALUE_BITS-1:0];
      if (in_if.valid && in_if.ready) expected_gaps = {expected_gaps, next_gap(in_if.restart)};
      if (out_if.valid && out_if.ready) begin
        if (expected_gaps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word prime=%0d gap=%0d done=%0b", $time,
                   out_if.prime_found, out_if.gap, out_if.done_res);
        end else begin
          exp_w = expected_gaps.pop_front();
          if (exp_w.done) dones_seen++;
          else primes_seen++;
          if (out_if.prime_found !== exp_w.prime) begin
            errors++;
            $display("%0t: prime_found expected %0d actual %0d", $time, exp_w.prime,
                     out_if.prime_found);
          end
          if (out_if.gap !== exp_w.gap) begin
            errors++;
            $display("%0t: gap expected %0d actual %0d", $time, exp_w.gap, out_if.gap);
          end
          if (out_if.done_res !== exp_w.done) begin
            errors++;
            $display("%0t: done_res expected %0b actual %0b", $time, exp_w.done,
                     out_if.done_res);
          end
        end
      end
      pending = expected_gaps.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Prime gap generator testbench: directed limit corners, then random limit
// phases with random restarts, random idling on both channels, one long
// result hold-off and a quiet stretch; the checker predicts every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import pgg_pkg::*;

  localparam int RANDOM_WORDS = 270;
  localparam int HOLD_CYCLES  = 4000;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 100;
  localparam logic [CFG_BITS-1:0] LIMIT_MAX = '1;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;

  int errors;
  int pending;
  int primes_seen;
  int dones_seen;
  int words_sent;
  int restarts_sent;
  int limits_set;
  int hold_at;
  int hold_left;
  bit hold_used;
  int quiet_from;
  int quiet_to;
  logic quiet;

  pgg_in_if  in_if ();
  pgg_out_if out_if ();

  prime_gap_generator_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  pgg_gap_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_if),
    .out_if      (out_if),
    .errors      (errors),
    .pending     (pending),
    .primes_seen (primes_seen),
    .dones_seen  (dones_seen)
  );

  assign quiet = (words_sent >= quiet_from) && (words_sent < quiet_to);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_used && words_sent >= hold_at) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  task automatic send_word(input logic restart);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limits_set++;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_MAX;
      2:       return CFG_BITS'($urandom_range(0, 20));
      3:       return {1'b1, 30'($urandom())};
      default: return CFG_BITS'($urandom_range(20, 600));
    endcase
  endfunction

  initial begin
    int n;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    words_sent    = 0;
    restarts_sent = 0;
    limits_set    = 0;
    hold_at       = 32'h7fff_ffff;
    quiet_from    = 32'h7fff_ffff;
    quiet_to      = 32'h7fff_ffff;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit 100
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    // limit 0: done, also right after a restart
    set_limit('0);
    send_word(1'b0);
    send_word(1'b1);
    // limit 3: only prime 3, then done
    set_limit(CFG_BITS'(3));
    send_word(1'b1);
    send_word(1'b0);
    // limit 12: scan runs out, then limit below candidate
    set_limit(CFG_BITS'(12));
    repeat (5) send_word(1'b0);
    // raised limit resumes where the scan stopped
    set_limit(CFG_BITS'(30));
    send_word(1'b0);
    send_word(1'b0);
    set_limit(LIMIT_MAX);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);

    hold_at    = words_sent + 5;
    quiet_from = words_sent + 150;
    quiet_to   = words_sent + 200;
    n          = words_sent + RANDOM_WORDS;
    while (words_sent < n) begin
      set_limit(pick_limit());
      repeat ($urandom_range(10, 40)) send_word($urandom_range(0, 24) == 0);
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d request words (%0d restarts) across %0d limit settings.",
             words_sent, restarts_sent, limits_set);
    $display("Checked %0d prime words and %0d done words.", primes_seen, dones_seen);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/pgg_pkg.sv
rtl/core/pgg_if.sv
rtl/core/pgg_mod_unit.sv
rtl/core/pgg_datapath.sv
rtl/core/pgg_ctrl.sv
rtl/core/prime_gap_generator_top.sv
rtl/core/pgg_checker.sv
verif/pgg_gap_checker.sv
verif/tb_top.sv
